// ===== rtl/io_fair_share_budget_throttle_unit_assert.svh =====
// ---------------------------------------------------------------------------
// fair-share throttle assertion macros
// clocked property checks, compiled out when ASSERT_OFF is set
// ---------------------------------------------------------------------------
`ifndef IO_FAIR_SHARE_BUDGET_THROTTLE_UNIT_ASSERT_SVH
`define IO_FAIR_SHARE_BUDGET_THROTTLE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// property checked at every rising edge outside reset
`define IFST_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ifst assertion failed");
// property checked at every rising edge, reset included
`define IFST_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ifst assertion failed");
`else
`define IFST_ASSERT(label, clk, rst, prop)
`define IFST_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== rtl/ifst_pkg.sv =====
// ---------------------------------------------------------------------------
// ifst_pkg
// shared types and constants of the fair-share i/o throttle
// ---------------------------------------------------------------------------
package ifst_pkg;

  // default priority range and weight offset
  localparam int PRIO_TOP_DEF    = 10;
  localparam int PRIO_OFFSET_DEF = 5;

  // saturation limits
  localparam logic [62:0] MAX63 = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;
  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

  // percent scale
  localparam logic [6:0] PCT_SCALE = 7'd100;

  // action codes
  localparam logic [1:0] ACT_REPORT = 2'd0;
  localparam logic [1:0] ACT_CLOSE  = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_FULL_PCT    = 2'd0;
  localparam logic [1:0] REG_RELEASE_PCT = 2'd1;
  localparam logic [1:0] REG_IDLE_STEP   = 2'd2;

  // register reset values
  localparam logic [6:0] FULL_PCT_RST    = 7'd90;
  localparam logic [6:0] RELEASE_PCT_RST = 7'd80;
  localparam logic [7:0] IDLE_STEP_RST   = 8'd5;

  typedef struct packed {
    logic [1:0]  action;
    logic [30:0] mean_latency;
    logic [30:0] transaction_count;
    logic [3:0]  priority_req;
    logic [30:0] current_limit;
    logic [30:0] issued_count;
    logic        rebalance_pending;
    logic        disk_idle;
    logic [30:0] elapsed_us;
    logic [30:0] idle_us;
  } in_t;

  typedef struct packed {
    logic [30:0] new_limit;
    logic        may_issue;
    logic [6:0]  busy_pct;
  } out_t;

endpackage

// ===== rtl/ifst_div.sv =====
// ---------------------------------------------------------------------------
// ifst_div
// shared restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module ifst_div
  import ifst_pkg::*;
#(
  parameter int NW = 68,
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] dsr;
  logic [NW-1:0] quo;
  logic [DW:0]   trial;
  logic          ge;

  // trial subtract of the next dividend bit
  always_comb begin
    trial = {rem, quo[NW-1]};
    ge    = (trial >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
        rem  <= '0;
        dsr  <= divisor;
        quo  <= dividend;
      end else if (busy) begin
        rem <= ge ? DW'(trial - {1'b0, dsr}) : trial[DW-1:0];
        quo <= {quo[NW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/io_fair_share_budget_throttle_unit.sv =====
// ---------------------------------------------------------------------------
// io_fair_share_budget_throttle_unit
// fair-share disk i/o throttle: per-priority budgets and stream limits
// ---------------------------------------------------------------------------
// One beat is taken at a time; in_stall stays high until its result beat is
// in the output register. A stream report multiplies, shifts, then halves the
// product and running total until the sum fits, or goes straight to the result
// when it carries no transactions. A limit query applies the limit rule, dividing
// the budget by the latency when the stream is limited, then the idle bump. An
// interval close uses the single bit-serial divider, which does the
// busy percent and then each active priority's budget
// in turn.
`include "io_fair_share_budget_throttle_unit_assert.svh"

module io_fair_share_budget_throttle_unit
  import ifst_pkg::*;
#(
  parameter int PRIO_TOP    = PRIO_TOP_DEF,
  parameter int PRIO_OFFSET = PRIO_OFFSET_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  localparam int NP = PRIO_TOP + 1;
  localparam int PW = (NP > 1) ? $clog2(NP) : 1;
  localparam int MW = $clog2(PRIO_OFFSET + PRIO_TOP + 1);
  localparam int NW = MW + 63;
  localparam int DW = 64;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_MUL   = 15'b000000000000010,
    S_SHIFT = 15'b000000000000100,
    S_NORM  = 15'b000000000001000,
    S_RULE  = 15'b000000000010000,
    S_QDIV  = 15'b000000000100000,
    S_BUMP  = 15'b000000001000000,
    S_BUSY  = 15'b000000010000000,
    S_BDIV  = 15'b000000100000000,
    S_SUM   = 15'b000001000000000,
    S_BSEL  = 15'b000010000000000,
    S_BWAIT = 15'b000100000000000,
    S_FLAGS = 15'b001000000000000,
    S_CLEAR = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_t;

  state_t        state;
  in_t           item;
  logic          may_en;
  logic [30:0]   nl;
  logic [61:0]   prod;
  logic [62:0]   total;
  logic [5:0]    lost;
  logic [31:0]   active;
  logic [6:0]    busy_level;
  logic          full_flag;
  logic          full_flag_old;
  logic [DW-1:0] sum;
  logic [PW-1:0] idx;
  logic [31:0]   counts [NP];
  logic [62:0]   budget [NP];

  logic [6:0]    full_pct;
  logic [6:0]    release_pct;
  logic [7:0]    idle_step;

  // divider port
  logic          div_start;
  logic [NW-1:0] div_dividend;
  logic [DW-1:0] div_divisor;
  logic          div_done;
  logic [NW-1:0] div_quo;

  // derived values
  logic [PW-1:0]    prio;
  logic [PW-1:0]    rd_idx;
  logic [31:0]      cnt_rd;
  logic [62:0]      bud_rd;
  logic             last_idx;
  logic [MW-1:0]    weight;
  logic [MW+31:0]   wcount;
  logic [30:0]      tot_us;
  logic             limited;
  logic             release_ok;
  logic [62:0]      q63;
  logic [62:0]      q_shifted;
  logic [31:0]      bump_sum;
  logic [30:0]      bumped;
  logic             accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  // clamp priority, pick the table row for this state
  always_comb begin
    if (int'(item.priority_req) > PRIO_TOP) prio = PW'(PRIO_TOP);
    else prio = PW'(item.priority_req);
    rd_idx   = (state == S_NORM || state == S_RULE) ? prio : idx;
    cnt_rd   = counts[rd_idx];
    bud_rd   = budget[rd_idx];
    last_idx = (idx == PW'(PRIO_TOP));
    weight   = MW'(PRIO_OFFSET + int'(idx));
    wcount   = (MW + 32)'(weight) * (MW + 32)'(cnt_rd);
    tot_us   = (item.elapsed_us == '0) ? 31'd1 : item.elapsed_us;
  end

  // limit rule conditions
  always_comb begin
    limited    = ({1'b0, prod} > bud_rd) && (busy_level >= full_pct);
    release_ok = (({1'b0, prod, 1'b0} < {1'b0, bud_rd}) || (busy_level < release_pct))
                 && !full_flag_old && !full_flag;
  end

  // budget quotient: saturate, then shift back by the lost bits
  always_comb begin
    q63 = (|div_quo[NW-1:63]) ? MAX63 : div_quo[62:0];
    if (q63 != '0 && (lost == 6'd63 || q63 > (MAX63 >> lost))) q_shifted = MAX63;
    else q_shifted = q63 << lost;
  end

  // idle bump with saturation
  always_comb begin
    bump_sum = {1'b0, nl} + 32'(idle_step);
    bumped   = bump_sum[31] ? MAX31 : bump_sum[30:0];
  end

  // operand selection for the shared divider
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state)
      S_RULE: begin
        if (item.rebalance_pending && limited) begin
          div_start    = 1'b1;
          div_dividend = NW'(bud_rd);
          div_divisor  = DW'(item.mean_latency);
        end
      end
      S_BUSY: begin
        if (item.idle_us < tot_us) begin
          div_start    = 1'b1;
          div_dividend = NW'(38'(PCT_SCALE) * 38'(tot_us - item.idle_us));
          div_divisor  = DW'(tot_us);
        end
      end
      S_BSEL: begin
        if (cnt_rd != '0) begin
          div_start    = 1'b1;
          div_dividend = NW'(weight) * NW'(total);
          div_divisor  = (sum == '0) ? DW'(1) : sum;
        end
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  ifst_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      full_pct    <= FULL_PCT_RST;
      release_pct <= RELEASE_PCT_RST;
      idle_step   <= IDLE_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FULL_PCT:    full_pct    <= cfg_wdata[6:0];
        REG_RELEASE_PCT: release_pct <= cfg_wdata[6:0];
        REG_IDLE_STEP:   idle_step   <= cfg_wdata;
        default:         full_pct    <= full_pct;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      total         <= '0;
      lost          <= '0;
      active        <= '0;
      busy_level    <= '0;
      full_flag     <= 1'b0;
      full_flag_old <= 1'b0;
      idx           <= '0;
      for (int k = 0; k < NP; k++) begin
        counts[k] <= '0;
        budget[k] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            item   <= in_data;
            nl     <= '0;
            may_en <= (in_data.action == ACT_REPORT) || (in_data.action == ACT_QUERY);
            case (in_data.action)
              ACT_REPORT: state <= S_MUL;
              ACT_QUERY:  state <= S_MUL;
              ACT_CLOSE:  state <= S_BUSY;
              default:    state <= S_DONE;
            endcase
          end
        end
        S_MUL: begin
          prod <= 62'(item.mean_latency) * 62'(item.transaction_count);
          if (item.action == ACT_REPORT) begin
            state <= (item.transaction_count == '0) ? S_DONE : S_SHIFT;
          end else begin
            state <= S_RULE;
          end
        end
        S_SHIFT: begin
          prod  <= prod >> lost;
          state <= S_NORM;
        end
        // halve product and total until the sum fits
        S_NORM: begin
          if (total >= MAX63 - {1'b0, prod}) begin
            if (lost != 6'd63) lost <= lost + 6'd1;
            prod  <= prod >> 1;
            total <= total >> 1;
          end else begin
            total <= total + {1'b0, prod};
            if (cnt_rd != MAX32) counts[prio] <= cnt_rd + 32'd1;
            if (active != MAX32) active <= active + 32'd1;
            nl    <= item.current_limit;
            state <= S_DONE;
          end
        end
        S_RULE: begin
          if (item.rebalance_pending && limited) begin
            state <= S_QDIV;
          end else begin
            if (item.rebalance_pending && release_ok) nl <= '0;
            else nl <= item.current_limit;
            state <= S_BUMP;
          end
        end
        S_QDIV: begin
          if (div_done) begin
            nl    <= (|div_quo[NW-1:31]) ? MAX31 : div_quo[30:0];
            state <= S_BUMP;
          end
        end
        S_BUMP: begin
          if (nl != '0 && item.disk_idle && item.issued_count >= nl) nl <= bumped;
          state <= S_DONE;
        end
        // busy percent of the closed interval
        S_BUSY: begin
          sum <= '0;
          idx <= '0;
          if (item.idle_us >= tot_us) begin
            busy_level <= '0;
            state      <= S_SUM;
          end else begin
            state <= S_BDIV;
          end
        end
        S_BDIV: begin
          if (div_done) begin
            busy_level <= div_quo[6:0];
            state      <= S_SUM;
          end
        end
        // weighted count sum, one priority a cycle
        S_SUM: begin
          sum <= sum + DW'(wcount);
          if (last_idx) begin
            idx   <= '0;
            state <= (active == '0) ? S_CLEAR : S_BSEL;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_BSEL: begin
          if (cnt_rd == '0) begin
            if (last_idx) state <= S_FLAGS;
            else idx <= idx + 1'b1;
          end else begin
            state <= S_BWAIT;
          end
        end
        S_BWAIT: begin
          if (div_done) begin
            budget[idx] <= q_shifted;
            if (last_idx) begin
              state <= S_FLAGS;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_BSEL;
            end
          end
        end
        S_FLAGS: begin
          full_flag_old <= full_flag;
          full_flag     <= (busy_level >= full_pct);
          state         <= S_CLEAR;
        end
        // interval accumulators start again
        S_CLEAR: begin
          for (int k = 0; k < NP; k++) counts[k] <= '0;
          total  <= '0;
          lost   <= '0;
          active <= '0;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_valid          <= 1'b1;
      out_data.new_limit <= nl;
      out_data.may_issue <= may_en && (nl == '0 || item.issued_count < nl);
      out_data.busy_pct  <= busy_level;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // checks
  `IFST_ASSERT(a_accept_leaves_idle, clk, rst, accept |=> (state != S_IDLE))
  `IFST_ASSERT(a_total_below_max, clk, rst, total != MAX63)
  `IFST_ASSERT(a_div_done_awaited, clk, rst,
    div_done |-> (state == S_QDIV || state == S_BDIV || state == S_BWAIT))

endmodule
